FILE: hdl/sbfr_pkg.sv
// Shared constants and types for the SBUS frame receiver.
// Used by the channel interfaces and every module of the block; depends on nothing.
package sbfr_pkg;

  localparam int FRAME_LEN    = 25;
  localparam int POS_W        = $clog2(FRAME_LEN);
  localparam int BYTE_W       = 8;
  localparam int CHAN_W       = 11;
  localparam int FAILSAFE_IDX = 3;
  localparam int FLAGS_POS    = FRAME_LEN - 2;
  localparam int END_POS      = FRAME_LEN - 1;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h0F;
  localparam logic [BYTE_W-1:0] END_BYTE   = 8'h00;

  // Decoupling queue between the framer and the decoder
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CHAN_W-1:0] chan_t;

  // One framed byte with its place in the frame
  typedef struct packed {
    byte_t data;
    pos_t  pos;
  } qentry_t;

endpackage

FILE: hdl/sbfr_channels.sv
// Handshake channel interfaces for the SBUS frame receiver.
// Depends on sbfr_pkg for field widths.
interface sbfr_in_if;
  logic               valid;
  logic               ready;
  sbfr_pkg::byte_t    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbfr_out_if;
  logic               valid;
  logic               ready;
  sbfr_pkg::chan_t    chan_zero;
  sbfr_pkg::chan_t    chan_one;
  sbfr_pkg::chan_t    chan_two;
  sbfr_pkg::chan_t    chan_three;
  sbfr_pkg::chan_t    chan_four;
  logic               link_good;

  modport source (output valid, output chan_zero, output chan_one, output chan_two,
                  output chan_three, output chan_four, output link_good, input ready);
  modport sink   (input valid, input chan_zero, input chan_one, input chan_two,
                  input chan_three, input chan_four, input link_good, output ready);
endinterface

FILE: hdl/sbfr_framer.sv
// Front end: accepts received bytes, hunts for the start byte and tags each
// framed byte with its position. Depends on sbfr_pkg and sbfr_in_if.
module sbfr_framer (
  input  logic                clk,
  input  logic                rst_n,
  sbfr_in_if.sink             in_bus,
  output logic                push_valid,
  input  logic                push_ready,
  output sbfr_pkg::qentry_t   push_data
);

  sbfr_pkg::pos_t pos_r, pos_nxt;
  logic           take;
  logic           hunting;

  assign hunting      = (pos_r == '0);
  assign in_bus.ready = push_ready;
  assign take         = in_bus.valid && push_ready;

  // Drop anything but the start byte while hunting
  assign push_valid     = in_bus.valid && !(hunting && in_bus.rx_byte != sbfr_pkg::START_BYTE);
  assign push_data.data = in_bus.rx_byte;
  assign push_data.pos  = pos_r;

  always_comb begin
    pos_nxt = pos_r;
    if (take && push_valid) begin
      if (pos_r == sbfr_pkg::POS_W'(sbfr_pkg::END_POS)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

FILE: hdl/sbfr_queue.sv
// Short FIFO that decouples the framer from the decoder.
// Depends on sbfr_pkg.
module sbfr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  sbfr_pkg::qentry_t   push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output sbfr_pkg::qentry_t   pop_data
);

  sbfr_pkg::qentry_t           slot_r [sbfr_pkg::QUEUE_DEPTH];
  logic [sbfr_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [sbfr_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [sbfr_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic                        do_push, do_pop;

  assign push_ready = (count_r != sbfr_pkg::QCNT_W'(sbfr_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == sbfr_pkg::QPTR_W'(sbfr_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == sbfr_pkg::QPTR_W'(sbfr_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hdl/sbfr_decoder.sv
// Back end: keeps the frame bytes that carry channels 0..4 and the flags,
// checks the end byte and unpacks the channels into the output register.
// Depends on sbfr_pkg and sbfr_out_if.
module sbfr_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  sbfr_pkg::qentry_t   pop_data,
  sbfr_out_if.source          out_bus
);

  localparam int FIRST_CH_BYTE = 1;
  localparam int LAST_CH_BYTE  = 7;

  sbfr_pkg::byte_t ch_byte_r [FIRST_CH_BYTE:LAST_CH_BYTE];
  sbfr_pkg::byte_t flags_r;
  logic            out_valid_r, out_valid_nxt;
  sbfr_pkg::chan_t chan_r [5];
  logic            link_good_r;
  logic            do_pop;
  logic            frame_ok;

  // Hold a finished frame until the sink takes it
  assign pop_ready = !out_valid_r || out_bus.ready;
  assign do_pop    = pop_valid && pop_ready;
  assign frame_ok  = do_pop && (pop_data.pos == sbfr_pkg::POS_W'(sbfr_pkg::END_POS)) &&
                     (pop_data.data == sbfr_pkg::END_BYTE);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (frame_ok) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = FIRST_CH_BYTE; i <= LAST_CH_BYTE; i++) begin
      if (do_pop && pop_data.pos == sbfr_pkg::POS_W'(i)) begin
        ch_byte_r[i] <= pop_data.data;
      end
    end
    if (do_pop && pop_data.pos == sbfr_pkg::POS_W'(sbfr_pkg::FLAGS_POS)) begin
      flags_r <= pop_data.data;
    end
  end

  // 11-bit little-endian fields packed across bytes 1..7
  always_ff @(posedge clk) begin
    if (frame_ok) begin
      chan_r[0]   <= {ch_byte_r[2][2:0], ch_byte_r[1]};
      chan_r[1]   <= {ch_byte_r[3][5:0], ch_byte_r[2][7:3]};
      chan_r[2]   <= {ch_byte_r[5][0], ch_byte_r[4], ch_byte_r[3][7:6]};
      chan_r[3]   <= {ch_byte_r[6][3:0], ch_byte_r[5][7:1]};
      chan_r[4]   <= {ch_byte_r[7][6:0], ch_byte_r[6][7:4]};
      link_good_r <= !flags_r[sbfr_pkg::FAILSAFE_IDX];
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.chan_zero  = chan_r[0];
  assign out_bus.chan_one   = chan_r[1];
  assign out_bus.chan_two   = chan_r[2];
  assign out_bus.chan_three = chan_r[3];
  assign out_bus.chan_four  = chan_r[4];
  assign out_bus.link_good  = link_good_r;

endmodule

FILE: hdl/sbus_frame_receiver.sv
// Top level of the SBUS frame receiver: framer, decoupling queue and decoder.
// Depends on sbfr_pkg, sbfr_channels.sv, sbfr_framer, sbfr_queue and sbfr_decoder.

// The receiver takes one serial byte per transaction on in_bus and accepts a
// byte every clock cycle for as long as the result side keeps up. While idle
// it drops every byte other than the 0x0F start byte; from the start byte on
// it counts 25 bytes as one frame (a 0x0F inside a frame is plain data, with no
// resync). A frame whose last byte is not 0x00 is dropped silently. A good
// frame gives one transaction on out_bus carrying the raw 11-bit values of
// channels 0 to 4 (unpacked little-endian from bytes 1 to 7) and link_good,
// which is low when the failsafe bit (bit 3 of byte 23) is set. The frame's
// last byte passes through the two-entry queue, and the decoder then registers
// the result and raises out_bus.valid. While a result waits on out_bus the
// decoder takes no more bytes; the queue fills up to its two entries (in
// steady back-to-back traffic it already holds one) and then in_bus.ready drops.
module sbus_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  sbfr_in_if.sink     in_bus,
  sbfr_out_if.source  out_bus
);

  logic              push_valid;
  logic              push_ready;
  sbfr_pkg::qentry_t push_data;
  logic              pop_valid;
  logic              pop_ready;
  sbfr_pkg::qentry_t pop_data;

  // Hunt for the start byte and tag framed bytes with their position
  sbfr_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouple the framer from a stalled result side
  sbfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Keep the channel and flag bytes, check the end byte, unpack the channels
  sbfr_decoder u_decoder (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_bus    (out_bus)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for sbus_frame_receiver: serial byte streams in, decoded channel samples out.
// Depends on sbfr_pkg, the channel interfaces in sbfr_channels.sv and the receiver RTL.
module tb_top;

  // Stop sending after this many accepted bytes, counting the directed part too
  localparam int TOTAL_BYTES  = 1450;
  // Run the last stretch of bytes with no gaps and no stalls
  localparam int CALM_TAIL    = 200;
  localparam int CYCLE_LIMIT  = 400000;
  // The result trails the frame's last byte through the queue and the output register, so this is plenty
  localparam int DRAIN_CYCLES = 20;
  // Bytes 1 to 23 of a frame: everything between the start byte and the end byte
  localparam int BODY_LEN     = sbfr_pkg::FRAME_LEN - 2;

  typedef struct packed {
    sbfr_pkg::chan_t chan_zero;
    sbfr_pkg::chan_t chan_one;
    sbfr_pkg::chan_t chan_two;
    sbfr_pkg::chan_t chan_three;
    sbfr_pkg::chan_t chan_four;
    logic            link_good;
  } chan_sample_t;

  typedef sbfr_pkg::byte_t frame_body_t [BODY_LEN];

  logic clk = 1'b0;
  logic rst_n;

  sbfr_in_if  in_bus ();
  sbfr_out_if out_bus ();

  sbus_frame_receiver u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // Shadow of the receiver: bytes of the frame in progress and how many are held
  sbfr_pkg::byte_t frame_bytes [sbfr_pkg::FRAME_LEN];
  int unsigned     frame_pos = 0;
  // Decoded samples still owed by the receiver, oldest first
  chan_sample_t pending_samples [$];

  bit          idle_on     = 1'b1;
  int unsigned bytes_sent  = 0;
  int unsigned samples_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the shadow receiver by one accepted byte. Return 1 and the sample
  // when the byte completes a frame with a good end byte.
  function bit frame_accept(input sbfr_pkg::byte_t b, output chan_sample_t s);
    logic [55:0] packed_bits;
    s = '0;
    // Drop anything but the start byte while idle
    if (frame_pos == 0 && b != sbfr_pkg::START_BYTE) return 1'b0;
    frame_bytes[frame_pos] = b;
    frame_pos++;
    if (frame_pos < sbfr_pkg::FRAME_LEN) return 1'b0;
    frame_pos = 0;
    // Bad end byte: the frame vanishes without a transaction
    if (frame_bytes[sbfr_pkg::END_POS] != sbfr_pkg::END_BYTE) return 1'b0;
    // Bytes 1..7 form one little-endian bit string; the channels sit 11 bits apart
    packed_bits = {frame_bytes[7], frame_bytes[6], frame_bytes[5], frame_bytes[4],
                   frame_bytes[3], frame_bytes[2], frame_bytes[1]};
    s.chan_zero  = packed_bits[10:0];
    s.chan_one   = packed_bits[21:11];
    s.chan_two   = packed_bits[32:22];
    s.chan_three = packed_bits[43:33];
    s.chan_four  = packed_bits[54:44];
    s.link_good  = ~frame_bytes[sbfr_pkg::FLAGS_POS][sbfr_pkg::FAILSAFE_IDX];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: sample %0d %s: got %0d, expected %0d",
             $time, samples_seen, what, got, want);
    error_count++;
  endtask

  // Offer one byte and hold it until the receiver takes it. An optional idle
  // gap goes in front while idling is on.
  task automatic send_byte(input sbfr_pkg::byte_t b);
    chan_sample_t s;
    int unsigned  gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    bytes_sent++;
    if (frame_accept(b, s)) pending_samples.push_back(s);
  endtask

  task automatic send_frame(input frame_body_t body, input sbfr_pkg::byte_t last);
    send_byte(sbfr_pkg::START_BYTE);
    foreach (body[i]) send_byte(body[i]);
    send_byte(last);
  endtask

  // Withdraw the input and hold off until every owed sample has come out
  task automatic drain_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Bytes other than the start byte while idle must all be dropped
  task automatic test_idle_noise();
    sbfr_pkg::byte_t noise [5] = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'hF0};
    foreach (noise[i]) send_byte(noise[i]);
    drain_results();
  endtask

  // Channel fields at both extremes, failsafe set and clear, start bytes as data
  task automatic test_extreme_frames();
    frame_body_t body;
    // All ones: every channel 2047, failsafe set so the link is down
    body = '{default: 8'hFF};
    send_frame(body, sbfr_pkg::END_BYTE);
    // All zeros: every channel 0, link good
    body = '{default: 8'h00};
    send_frame(body, sbfr_pkg::END_BYTE);
    // Start bytes inside the frame stay plain data; 0x0F also carries failsafe
    body = '{default: sbfr_pkg::START_BYTE};
    send_frame(body, sbfr_pkg::END_BYTE);
    drain_results();
  endtask

  // Wrong end bytes (0xFF, then 0x0F) drop the frame; a later good frame must still decode
  task automatic test_bad_end();
    frame_body_t body;
    foreach (body[i]) body[i] = sbfr_pkg::byte_t'($urandom_range(0, 255));
    send_frame(body, 8'hFF);
    foreach (body[i]) body[i] = sbfr_pkg::byte_t'($urandom_range(0, 255));
    send_frame(body, sbfr_pkg::START_BYTE);
    // Other flag bits set, failsafe clear
    body = '{default: 8'hAA};
    body[sbfr_pkg::FLAGS_POS - 1] = 8'hF7;
    send_frame(body, sbfr_pkg::END_BYTE);
    drain_results();
  endtask

  // Mostly well-formed frames with random content; the rest are frames with a
  // bad end byte, noise between frames and frames cut short, which knock the
  // receiver out of step with the sender until a later start byte recovers it.
  task automatic test_random_traffic();
    frame_body_t body;
    int unsigned pick;
    int unsigned cut;
    bit          paused;
    paused = 1'b0;
    while (bytes_sent < TOTAL_BYTES) begin
      if (bytes_sent >= TOTAL_BYTES - CALM_TAIL) begin
        idle_on = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      // Hold the sender once midway until the result side has caught up
      if (!paused && bytes_sent >= TOTAL_BYTES / 2) begin
        drain_results();
        paused = 1'b1;
      end
      foreach (body[i]) body[i] = sbfr_pkg::byte_t'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        send_frame(body, sbfr_pkg::END_BYTE);
      end else if (pick < 88) begin
        send_frame(body, sbfr_pkg::byte_t'($urandom_range(1, 255)));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 6)) send_byte(sbfr_pkg::byte_t'($urandom_range(0, 255)));
      end else begin
        cut = $urandom_range(1, BODY_LEN - 1);
        send_byte(sbfr_pkg::START_BYTE);
        for (int i = 0; i < cut; i++) send_byte(body[i]);
      end
    end
  endtask

  // Result side: stall in random bursts while idling is on
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_bus.ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_bus.ready <= 1'b0;
      stall_left = $urandom_range(0, 10);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Compare every result transaction with the oldest owed sample
  always @(posedge clk) begin : sample_check
    chan_sample_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("arrived with none owed, owed count", 1, 0);
      end else begin
        want = pending_samples.pop_front();
        if (out_bus.chan_zero !== want.chan_zero)
          report_mismatch("chan_zero", out_bus.chan_zero, want.chan_zero);
        if (out_bus.chan_one !== want.chan_one)
          report_mismatch("chan_one", out_bus.chan_one, want.chan_one);
        if (out_bus.chan_two !== want.chan_two)
          report_mismatch("chan_two", out_bus.chan_two, want.chan_two);
        if (out_bus.chan_three !== want.chan_three)
          report_mismatch("chan_three", out_bus.chan_three, want.chan_three);
        if (out_bus.chan_four !== want.chan_four)
          report_mismatch("chan_four", out_bus.chan_four, want.chan_four);
        if (out_bus.link_good !== want.link_good)
          report_mismatch("link_good", out_bus.link_good, want.link_good);
      end
      samples_seen++;
    end
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.rx_byte = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_noise();
    test_extreme_frames();
    test_bad_end();
    test_random_traffic();
    drain_results();

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
